// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; compiled out by NO_ASSERTIONS.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/spq_pkg.sv =====
// -----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, and the cell control struct.
// -----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
// -----------------------------------------------------------------------------
// Queue cell
// Holds one stored value; on insert it keeps, takes the new value or takes its
// left neighbor, and on delete it takes its right neighbor.
// -----------------------------------------------------------------------------
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic                              occupied,
	input  logic signed [spq_pkg::DATA_W-1:0] ins_value,
	input  logic                              left_gt,
	input  logic signed [spq_pkg::DATA_W-1:0] left_value,
	input  logic signed [spq_pkg::DATA_W-1:0] right_value,
	output logic signed [spq_pkg::DATA_W-1:0] value_q,
	output logic                              gt
);
	import spq_pkg::*;

	// An empty cell counts as greater than any value.
	assign gt = !occupied || (value_q > ins_value);

	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			value_q <= left_gt ? left_value : ins_value;
		end else if (ctl.del) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// -----------------------------------------------------------------------------
// Sorted priority queue
// Shift-register priority queue of signed values in ascending order.
//
//   channel | handshake            | fields
//   --------+----------------------+----------------------------------
//   in      | in_valid / in_stall  | cmd, value
//   out     | out_valid / out_stall| status, removed_value, occupancy
//
// Each accepted item is applied to all cells at once; they compare and shift in parallel.
// One result register plus one skid register sit on the output.
// The input stalls only while the skid register holds a result.
// Reset empties the queue at once; stored values need no clearing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic signed [spq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [spq_pkg::DATA_W-1:0] removed_value,
	output logic [spq_pkg::OCC_W-1:0]         occupancy
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	logic                     cell_gt    [CAPACITY];
	cell_ctl_t                ctl;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic                     accept;
	logic                     is_full;
	logic                     is_empty;

	status_t                  res_status;
	logic signed [DATA_W-1:0] res_removed;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_removed_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     skid_valid_q;
	status_t                  skid_status_q;
	logic signed [DATA_W-1:0] skid_removed_q;
	logic [CNT_W-1:0]         skid_count_q;
	logic                     out_take;

	logic                     empty_delete;
	logic                     full_insert;

	assign accept   = in_valid && !in_stall;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctl.ins     = 1'b0;
		ctl.del     = 1'b0;
		res_status  = ST_OK;
		res_removed = '0;
		count_next  = count_q;
		if (cmd == CMD_INSERT) begin
			if (is_full) begin
				res_status = ST_FULL;
			end else begin
				ctl.ins    = accept;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				res_status = ST_EMPTY;
			end else begin
				ctl.del     = accept;
				res_removed = cell_value[0];
				count_next  = count_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_gt;
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_value = value;
		end else begin : g_body
			assign left_gt    = cell_gt[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (CNT_W'(i) < count_q),
			.ins_value   (value),
			.left_gt     (left_gt),
			.left_value  (left_value),
			.right_value (right_value),
			.value_q     (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_status_q  <= skid_status_q;
				out_removed_q <= skid_removed_q;
				out_count_q   <= skid_count_q;
			end
		end else if (accept) begin
			if (!out_valid_q || out_take) begin
				out_status_q  <= res_status;
				out_removed_q <= res_removed;
				out_count_q   <= count_next;
			end else begin
				skid_status_q  <= res_status;
				skid_removed_q <= res_removed;
				skid_count_q   <= count_next;
			end
		end
	end

	assign in_stall      = skid_valid_q;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign occupancy     = OCC_W'(out_count_q);

	assign empty_delete = accept && (cmd == CMD_DELETE) && is_empty;
	assign full_insert  = accept && (cmd == CMD_INSERT) && is_full;

	`ASSERT_ALWAYS(a_skid_behind_out, clk, arst_n, !skid_valid_q || out_valid_q)
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`ASSERT_NEXT(a_empty_delete_keeps, clk, arst_n, empty_delete, count_q == '0)
	`ASSERT_NEXT(a_full_insert_keeps, clk, arst_n, full_insert, count_q == CNT_W'(CAPACITY))

endmodule
